[src/static_linked_list_engine_macros.svh]
// Assertion helpers for the linked list engine checker.
// Both expect clk_i and rst_ni to be visible where they are used.
`ifndef STATIC_LINKED_LIST_ENGINE_MACROS_SVH
`define STATIC_LINKED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication.
`define SLL_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sll assertion failed");

// Next-cycle implication.
`define SLL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sll assertion failed");

`endif

[src/sll_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sll_pkg;

  localparam int NODES       = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int NODE_AW     = $clog2(NODES);
  localparam int HEAD_NODE   = NODES - 1;
  localparam int POS_W       = 10;
  localparam int CMP_W       = ((POS_W > NODE_AW) ? POS_W : NODE_AW) + 1;

  localparam logic [2:0] ACT_INSERT = 3'd0;
  localparam logic [2:0] ACT_DELETE = 3'd1;
  localparam logic [2:0] ACT_GET    = 3'd2;
  localparam logic [2:0] ACT_LOCATE = 3'd3;
  localparam logic [2:0] ACT_CLEAR  = 3'd4;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_BAD_POS = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_FREE,
    ST_INS_JN,
    ST_WALK,
    ST_INS_LK,
    ST_INS_HD,
    ST_DEL_JN,
    ST_DEL_F,
    ST_DEL_LJ,
    ST_DEL_HD,
    ST_GET,
    ST_LOC,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]                    action;
    logic [POS_W-1:0]              position;
    logic signed [VALUE_WIDTH-1:0] item_value;
  } in_req_t;

  typedef struct packed {
    logic [1:0]                    status;
    logic signed [VALUE_WIDTH-1:0] read_value;
    logic [POS_W-1:0]              found_position;
    logic [POS_W-1:0]              list_length;
    logic                          list_empty;
  } out_rsp_t;

  typedef struct packed {
    logic                   rd_en;
    logic [NODE_AW-1:0]     rd_addr;
    logic                   link_we;
    logic                   value_we;
    logic [NODE_AW-1:0]     wr_addr;
    logic [NODE_AW-1:0]     wr_link;
    logic [VALUE_WIDTH-1:0] wr_value;
  } mem_req_t;

  typedef struct packed {
    logic [NODE_AW-1:0]     link;
    logic [VALUE_WIDTH-1:0] value;
  } mem_rsp_t;

endpackage
`default_nettype wire

[src/sll_node_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// Node store: link and value arrays, one write and one registered read per cycle.
module sll_node_mem import sll_pkg::*; (
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output mem_rsp_t      rsp_o
);

  logic [NODE_AW-1:0]     link_mem  [NODES];
  logic [VALUE_WIDTH-1:0] value_mem [NODES];
  logic [NODE_AW-1:0]     link_rd_q;
  logic [VALUE_WIDTH-1:0] value_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.link_we) begin
      link_mem[req_i.wr_addr] <= req_i.wr_link;
    end
    if (req_i.rd_en) begin
      link_rd_q <= link_mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.value_we) begin
      value_mem[req_i.wr_addr] <= req_i.wr_value;
    end
    if (req_i.rd_en) begin
      value_rd_q <= value_mem[req_i.rd_addr];
    end
  end

  assign rsp_o.link  = link_rd_q;
  assign rsp_o.value = value_rd_q;

endmodule
`default_nettype wire

[src/sll_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: walks the link chain through the node store and patches links.
module sll_ctrl import sll_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire in_req_t  in_req_i,
  output logic          in_stall_o,
  input  wire logic     out_free_i,
  output logic          res_valid_o,
  output out_rsp_t      res_o,
  output mem_req_t      mem_req_o,
  input  wire mem_rsp_t mem_rsp_i
);

  localparam logic [NODE_AW-1:0] HEAD = NODE_AW'(HEAD_NODE);
  localparam logic [NODE_AW-1:0] FREE = '0;

  state_e                 state_q, state_d;
  logic [2:0]             act_q, act_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [NODE_AW-1:0]     cnt_q, cnt_d;
  logic [NODE_AW-1:0]     steps_q, steps_d;
  logic [NODE_AW-1:0]     idx_q, idx_d;
  logic [NODE_AW-1:0]     k_q, k_d;
  logic [NODE_AW-1:0]     j_q, j_d;
  logic [NODE_AW-1:0]     jn_q, jn_d;
  logic [NODE_AW-1:0]     f_q, f_d;
  logic [NODE_AW-1:0]     clr_q, clr_d;
  logic                   clr_resp_q, clr_resp_d;
  logic [1:0]             status_q, status_d;
  logic [VALUE_WIDTH-1:0] rd_q, rd_d;
  logic [NODE_AW-1:0]     found_q, found_d;

  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic             ins_bad;
  logic             pos_bad;
  logic             no_free;
  logic             loc_hit;

  assign pos_w   = CMP_W'(in_req_i.position);
  assign cnt_w   = CMP_W'(cnt_q);
  assign ins_bad = (pos_w == '0) || (pos_w > cnt_w + CMP_W'(1));
  assign pos_bad = (pos_w == '0) || (pos_w > cnt_w);
  assign no_free = (mem_rsp_i.link == FREE) || (mem_rsp_i.link >= HEAD);
  assign loc_hit = (idx_q != '0) && (mem_rsp_i.value == val_q);

  assign in_stall_o = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == HEAD) begin
          state_d = clr_resp_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_req_i.action)
            ACT_INSERT: state_d = ins_bad ? ST_RESP : ST_INS_FREE;
            ACT_DELETE: state_d = pos_bad ? ST_RESP : ST_WALK;
            ACT_GET:    state_d = pos_bad ? ST_RESP : ST_WALK;
            ACT_LOCATE: state_d = (cnt_q == '0) ? ST_RESP : ST_LOC;
            ACT_CLEAR:  state_d = ST_CLEAR;
            default:    state_d = ST_RESP;
          endcase
        end
      end
      ST_INS_FREE: state_d = no_free ? ST_RESP : ST_INS_JN;
      ST_INS_JN:   state_d = ST_WALK;
      ST_WALK: begin
        if (steps_q == '0) begin
          case (act_q)
            ACT_INSERT: state_d = ST_INS_LK;
            ACT_DELETE: state_d = ST_DEL_JN;
            default:    state_d = ST_GET;
          endcase
        end
      end
      ST_INS_LK: state_d = ST_INS_HD;
      ST_INS_HD: state_d = ST_RESP;
      ST_DEL_JN: state_d = ST_DEL_F;
      ST_DEL_F:  state_d = ST_DEL_LJ;
      ST_DEL_LJ: state_d = ST_DEL_HD;
      ST_DEL_HD: state_d = ST_RESP;
      ST_GET:    state_d = ST_RESP;
      ST_LOC: begin
        if (loc_hit || (idx_q == cnt_q)) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    act_d       = act_q;
    val_d       = val_q;
    cnt_d       = cnt_q;
    steps_d     = steps_q;
    idx_d       = idx_q;
    k_d         = k_q;
    j_d         = j_q;
    jn_d        = jn_q;
    f_d         = f_q;
    clr_d       = clr_q;
    clr_resp_d  = clr_resp_q;
    status_d    = status_q;
    rd_d        = rd_q;
    found_d     = found_q;
    res_valid_o = 1'b0;
    mem_req_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_req_o.link_we  = 1'b1;
        mem_req_o.value_we = 1'b1;
        mem_req_o.wr_addr  = clr_q;
        mem_req_o.wr_link  = (clr_q == HEAD) ? FREE : clr_q + NODE_AW'(1);
        mem_req_o.wr_value = '0;
        clr_d              = clr_q + NODE_AW'(1);
        if (clr_q == HEAD) begin
          clr_resp_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d    = in_req_i.action;
          val_d    = in_req_i.item_value;
          steps_d  = NODE_AW'(pos_w - CMP_W'(1));
          idx_d    = '0;
          k_d      = HEAD;
          status_d = STS_OK;
          rd_d     = '0;
          found_d  = '0;
          case (in_req_i.action)
            ACT_INSERT: begin
              if (ins_bad) begin
                status_d = STS_BAD_POS;
              end else begin
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = FREE;
              end
            end
            ACT_DELETE, ACT_GET: begin
              if (pos_bad) begin
                status_d = STS_BAD_POS;
              end else begin
                mem_req_o.rd_en   = 1'b1;
                mem_req_o.rd_addr = HEAD;
              end
            end
            ACT_LOCATE: begin
              mem_req_o.rd_en   = 1'b1;
              mem_req_o.rd_addr = HEAD;
            end
            ACT_CLEAR: begin
              clr_d      = '0;
              clr_resp_d = 1'b1;
              cnt_d      = '0;
            end
            default: ;
          endcase
        end
      end
      ST_INS_FREE: begin
        if (no_free) begin
          status_d = STS_FULL;
        end else begin
          j_d               = mem_rsp_i.link;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = mem_rsp_i.link;
        end
      end
      ST_INS_JN: begin
        jn_d              = mem_rsp_i.link;
        k_d               = HEAD;
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = HEAD;
      end
      ST_WALK: begin
        if (steps_q != '0) begin
          k_d               = mem_rsp_i.link;
          steps_d           = steps_q - NODE_AW'(1);
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = mem_rsp_i.link;
        end else begin
          case (act_q)
            ACT_INSERT: begin
              // new node takes over the successor of its predecessor
              mem_req_o.link_we  = 1'b1;
              mem_req_o.value_we = 1'b1;
              mem_req_o.wr_addr  = j_q;
              mem_req_o.wr_link  = mem_rsp_i.link;
              mem_req_o.wr_value = val_q;
            end
            ACT_DELETE: begin
              j_d               = mem_rsp_i.link;
              mem_req_o.rd_en   = 1'b1;
              mem_req_o.rd_addr = mem_rsp_i.link;
            end
            default: begin
              mem_req_o.rd_en   = 1'b1;
              mem_req_o.rd_addr = mem_rsp_i.link;
            end
          endcase
        end
      end
      ST_INS_LK: begin
        mem_req_o.link_we = 1'b1;
        mem_req_o.wr_addr = k_q;
        mem_req_o.wr_link = j_q;
      end
      ST_INS_HD: begin
        mem_req_o.link_we = 1'b1;
        mem_req_o.wr_addr = FREE;
        mem_req_o.wr_link = jn_q;
        cnt_d             = cnt_q + NODE_AW'(1);
      end
      ST_DEL_JN: begin
        jn_d              = mem_rsp_i.link;
        mem_req_o.rd_en   = 1'b1;
        mem_req_o.rd_addr = FREE;
      end
      ST_DEL_F: begin
        f_d               = mem_rsp_i.link;
        mem_req_o.link_we = 1'b1;
        mem_req_o.wr_addr = k_q;
        mem_req_o.wr_link = jn_q;
      end
      ST_DEL_LJ: begin
        mem_req_o.link_we = 1'b1;
        mem_req_o.wr_addr = j_q;
        mem_req_o.wr_link = f_q;
      end
      ST_DEL_HD: begin
        mem_req_o.link_we = 1'b1;
        mem_req_o.wr_addr = FREE;
        mem_req_o.wr_link = j_q;
        cnt_d             = cnt_q - NODE_AW'(1);
      end
      ST_GET: begin
        rd_d = mem_rsp_i.value;
      end
      ST_LOC: begin
        if (loc_hit) begin
          found_d = idx_q;
        end else if (idx_q != cnt_q) begin
          idx_d             = idx_q + NODE_AW'(1);
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = mem_rsp_i.link;
        end
      end
      ST_RESP: begin
        res_valid_o = out_free_i;
      end
      default: ;
    endcase
  end

  assign res_o.status         = status_q;
  assign res_o.read_value     = rd_q;
  assign res_o.found_position = POS_W'(found_q);
  assign res_o.list_length    = POS_W'(cnt_q);
  assign res_o.list_empty     = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      cnt_q      <= '0;
      clr_q      <= '0;
      clr_resp_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      clr_q      <= clr_d;
      clr_resp_q <= clr_resp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    val_q    <= val_d;
    steps_q  <= steps_d;
    idx_q    <= idx_d;
    k_q      <= k_d;
    j_q      <= j_d;
    jn_q     <= jn_d;
    f_q      <= f_d;
    status_q <= status_d;
    rd_q     <= rd_d;
    found_q  <= found_d;
  end

endmodule
`default_nettype wire

[src/static_linked_list_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of signed values kept as a static linked list in a node store of
// NODES entries (entry 0 heads the free chain, the last entry heads the list,
// at most NODES-2 elements). Each request (insert, delete, get, locate, clear)
// yields exactly one response with status, value, found position and length.
// Requests are served one at a time; each one walks the link chain with one
// node store read per list node passed. Out-of-range and full requests skip
// the walk. After reset the block rebuilds the node store and holds
// in_stall_o high until it is done.
module static_linked_list_engine import sll_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  // request channel
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire in_req_t in_req_i,
  // response channel
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_rsp_t     out_rsp_o
);

  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  out_rsp_t res;
  logic     res_valid;
  logic     out_free;
  logic     out_valid_q, out_valid_d;
  out_rsp_t out_rsp_q;

  // The response register frees when empty or being taken this cycle, so the
  // sequencer can finish a request while the previous response drains.
  assign out_free = !out_valid_q || !out_stall_i;

  sll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .in_stall_o  (in_stall_o),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rsp_i   (mem_rsp)
  );

  sll_node_mem u_mem (
    .clk_i (clk_i),
    .req_i (mem_req),
    .rsp_o (mem_rsp)
  );

  // Hold the response while stalled, drop it once taken, load a new one.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
`default_nettype wire

[src/sll_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "static_linked_list_engine_macros.svh"
module sll_checker import sll_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire out_rsp_t out_rsp_o
);

  `SLL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))
  `SLL_ASSERT(a_empty_flag, out_valid_o, out_rsp_o.list_empty == (out_rsp_o.list_length == '0))
  `SLL_ASSERT(a_status_code, out_valid_o, out_rsp_o.status != 2'd3)
  `SLL_ASSERT(a_fail_zero, out_valid_o && (out_rsp_o.status != STS_OK), (out_rsp_o.read_value == '0) && (out_rsp_o.found_position == '0))
  `SLL_ASSERT(a_len_bound, out_valid_o, int'(out_rsp_o.list_length) <= NODES - 2)

endmodule

bind static_linked_list_engine sll_checker u_sll_checker (.*);
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import sll_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 8;
  localparam int GAP_MAX         = 11;
  localparam int MAX_ELEMS       = NODES - 2;
  localparam int POS_MAX         = (1 << POS_W) - 1;
  localparam int RANDOM_REQUESTS = 541;
  localparam int HOLDOFF_AT      = 300;
  localparam int HOLDOFF_CYCLES  = 600;
  localparam int POOL_N          = 8;

  // Action codes the block treats as no-ops.
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  // One queued request plus its pacing on the request side.
  typedef struct {
    in_req_t req;
    int      gap;    // idle cycles after the previous request was taken
    bit      drain;  // hold this request until every response is back
  } list_request_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  in_req_t  in_req    = '0;
  logic     out_stall = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  out_rsp_t out_rsp;

  list_request_t pending_requests[$];
  out_rsp_t      awaited_responses[$];

  int     gap_cnt   = 0;
  int     hold_left = 0;
  int     n_sent    = 0;
  int     n_got     = 0;
  int     gen_len   = 0;   // list length as the request generator sees it
  int     total_requests;
  bit     quiet     = 1'b0;
  bit     failed    = 1'b0;
  longint cycle_count = 0;
  longint cycle_limit = 64'd100_000_000;

  logic [31:0] value_pool [POOL_N];

  // Mirror of the node store: free chain starts at entry 0, list at HEAD_NODE.
  logic [NODE_AW-1:0]     list_link  [NODES];
  logic [VALUE_WIDTH-1:0] list_value [NODES];
  int                     list_count;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  static_linked_list_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  // Rebuild the free chain and zero every value, as after reset or a clear.
  function automatic void rebuild_list();
    for (int i = 0; i < NODES; i++) begin
      list_link[i]  = (i == HEAD_NODE) ? '0 : NODE_AW'(i + 1);
      list_value[i] = '0;
    end
    list_count = 0;
  endfunction

  // Entry that precedes list position pos; position 1 sits behind the head.
  function automatic int node_before(int pos);
    int k;
    k = HEAD_NODE;
    for (int l = 1; l < pos; l++) k = list_link[k];
    return k;
  endfunction

  // Apply one request to the mirror and return the response it must produce.
  function automatic out_rsp_t apply_list_action(in_req_t req);
    out_rsp_t rsp;
    int       pos;
    int       j;
    int       k;
    rsp        = '0;
    rsp.status = STS_OK;
    pos        = int'(req.position);
    case (req.action)
      ACT_INSERT: begin
        // Position is judged before the free chain is looked at.
        if (pos < 1 || pos > list_count + 1) begin
          rsp.status = STS_BAD_POS;
        end else begin
          j = list_link[0];
          if (j == 0 || j >= HEAD_NODE) begin
            rsp.status = STS_FULL;
          end else begin
            list_link[0]  = list_link[j];
            list_value[j] = req.item_value;
            k             = node_before(pos);
            list_link[j]  = list_link[k];
            list_link[k]  = NODE_AW'(j);
            list_count++;
          end
        end
      end
      ACT_DELETE: begin
        if (pos < 1 || pos > list_count) begin
          rsp.status = STS_BAD_POS;
        end else begin
          // Unlink the node and push it onto the front of the free chain.
          k            = node_before(pos);
          j            = list_link[k];
          list_link[k] = list_link[j];
          list_link[j] = list_link[0];
          list_link[0] = NODE_AW'(j);
          list_count--;
        end
      end
      ACT_GET: begin
        if (pos < 1 || pos > list_count) begin
          rsp.status = STS_BAD_POS;
        end else begin
          rsp.read_value = list_value[list_link[node_before(pos)]];
        end
      end
      ACT_LOCATE: begin
        // Search every element, stop at the first match.
        k = HEAD_NODE;
        for (int i = 1; i <= list_count; i++) begin
          k = list_link[k];
          if (list_value[k] == req.item_value) begin
            rsp.found_position = POS_W'(i);
            break;
          end
        end
      end
      ACT_CLEAR: begin
        rebuild_list();
      end
      default: begin
      end
    endcase
    rsp.list_length = POS_W'(list_count);
    rsp.list_empty  = (list_count == 0);
    return rsp;
  endfunction

  function automatic void report_field(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    failed = 1'b1;
  endfunction

  function automatic void compare_response(out_rsp_t want, out_rsp_t got);
    if (got.status !== want.status)
      report_field("status", 32'(want.status), 32'(got.status));
    if (got.read_value !== want.read_value)
      report_field("read_value", want.read_value, got.read_value);
    if (got.found_position !== want.found_position)
      report_field("found_position", 32'(want.found_position), 32'(got.found_position));
    if (got.list_length !== want.list_length)
      report_field("list_length", 32'(want.list_length), 32'(got.list_length));
    if (got.list_empty !== want.list_empty)
      report_field("list_empty", 32'(want.list_empty), 32'(got.list_empty));
  endfunction

  // Half the values come from a small pool so that locate hits and duplicates occur.
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 1) == 0) return value_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  // Legal position up to limit (zero if there is none), mostly near the head to keep walks short.
  function automatic int in_range_pos(int limit);
    if (limit < 1) return 0;
    if ($urandom_range(0, 7) == 0) return $urandom_range(1, limit);
    if ($urandom_range(0, 7) == 0) return limit;
    return $urandom_range(1, (limit < 12) ? limit : 12);
  endfunction

  // Position beyond the legal range, or zero.
  function automatic int off_range_pos(int limit);
    if (limit >= POS_MAX || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(limit + 1, POS_MAX);
  endfunction

  // Queue one request and track the list length it leaves behind.
  function automatic void queue_request(logic [2:0] act, int pos, logic [31:0] value,
                                        bit drain);
    list_request_t r;
    r.req.action     = act;
    r.req.position   = POS_W'(pos);
    r.req.item_value = value;
    r.drain          = drain;
    r.gap            = quiet ? 0 : $urandom_range(0, GAP_MAX);
    pending_requests.push_back(r);
    case (act)
      ACT_INSERT: if (pos >= 1 && pos <= gen_len + 1 && gen_len < MAX_ELEMS) gen_len++;
      ACT_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
      ACT_CLEAR:  gen_len = 0;
      default: begin
      end
    endcase
    // Switch between gap-free stretches and idling every 40 requests.
    if (pending_requests.size() % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
  endfunction

  initial begin : stimulus
    int         sel;
    logic [2:0] act;
    value_pool[0] = 32'h7FFF_FFFF;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_N; i++) value_pool[i] = $urandom;
    rebuild_list();

    // Directed: empty-list errors, ends and middle, value extremes, duplicates.
    queue_request(ACT_GET,    1, pick_value(), 1'b0);
    queue_request(ACT_DELETE, 1, pick_value(), 1'b0);
    queue_request(ACT_LOCATE, 0, value_pool[2], 1'b0);
    queue_request(ACT_INSERT, 0, pick_value(), 1'b0);
    queue_request(ACT_INSERT, 2, pick_value(), 1'b0);
    queue_request(ACT_INSERT, 1, value_pool[0], 1'b0);
    queue_request(ACT_INSERT, 2, value_pool[1], 1'b0);
    queue_request(ACT_INSERT, 1, value_pool[2], 1'b0);
    queue_request(ACT_INSERT, 2, value_pool[3], 1'b0);
    queue_request(ACT_INSERT, POS_MAX, pick_value(), 1'b0);
    queue_request(ACT_GET,    4, pick_value(), 1'b0);
    queue_request(ACT_GET,    5, pick_value(), 1'b0);
    queue_request(ACT_GET,    0, pick_value(), 1'b0);
    queue_request(ACT_LOCATE, 0, value_pool[1], 1'b0);
    queue_request(ACT_INSERT, 3, value_pool[2], 1'b0);
    queue_request(ACT_LOCATE, 0, value_pool[2], 1'b0);
    queue_request(ACT_LOCATE, POS_MAX, 32'h0001_2345, 1'b0);
    queue_request(ACT_DELETE, 5, pick_value(), 1'b0);
    queue_request(ACT_DELETE, 1, pick_value(), 1'b0);
    queue_request(ACT_DELETE, 2, pick_value(), 1'b0);
    queue_request(ACT_DELETE, POS_MAX, pick_value(), 1'b0);
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
      queue_request(3'(a), $urandom_range(0, POS_MAX), $urandom, 1'b0);
    queue_request(ACT_CLEAR, $urandom_range(0, POS_MAX), $urandom, 1'b0);

    // Random: mostly legal operations on a growing list, some errors and noise.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        queue_request(ACT_INSERT, in_range_pos(gen_len + 1), pick_value(), n % 120 == 0);
      end else if (sel < 58) begin
        queue_request(ACT_DELETE, in_range_pos(gen_len), pick_value(), n % 120 == 0);
      end else if (sel < 70) begin
        queue_request(ACT_GET, in_range_pos(gen_len), pick_value(), n % 120 == 0);
      end else if (sel < 82) begin
        queue_request(ACT_LOCATE, $urandom_range(0, POS_MAX), pick_value(), n % 120 == 0);
      end else if (sel < 93) begin
        act = (sel < 86) ? ACT_INSERT : (sel < 90) ? ACT_DELETE : ACT_GET;
        queue_request(act, off_range_pos((act == ACT_INSERT) ? gen_len + 1 : gen_len),
                      pick_value(), n % 120 == 0);
      end else if (sel < 97) begin
        queue_request(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                      $urandom_range(0, POS_MAX), $urandom, n % 120 == 0);
      end else begin
        queue_request(ACT_CLEAR, $urandom_range(0, POS_MAX), $urandom, n % 120 == 0);
      end
    end

    // Poke at positions up to and past the largest list length.
    queue_request(ACT_LOCATE, 0, pick_value(), 1'b1);
    queue_request(ACT_INSERT, MAX_ELEMS + 1, pick_value(), 1'b0);
    queue_request(ACT_INSERT, 1, pick_value(), 1'b0);
    queue_request(ACT_INSERT, 0, pick_value(), 1'b0);
    queue_request(ACT_GET,    MAX_ELEMS, pick_value(), 1'b0);
    queue_request(ACT_GET,    MAX_ELEMS + 1, pick_value(), 1'b0);
    queue_request(ACT_LOCATE, 0, 32'h5A5A_0001, 1'b0);
    queue_request(ACT_DELETE, MAX_ELEMS, pick_value(), 1'b0);
    queue_request(ACT_INSERT, MAX_ELEMS, pick_value(), 1'b0);
    queue_request(ACT_DELETE, 1, pick_value(), 1'b1);
    queue_request(ACT_CLEAR,  0, pick_value(), 1'b0);
    queue_request(ACT_GET,    1, pick_value(), 1'b0);
    queue_request(ACT_INSERT, 1, value_pool[3], 1'b0);
    queue_request(ACT_LOCATE, 0, value_pool[3], 1'b0);

    // Budget each request a full walk plus both sides' longest idle, then triple it.
    total_requests = pending_requests.size();
    cycle_limit = 3 * (longint'(total_requests) * (NODES + 2 * GAP_MAX + 16) +
                       HOLDOFF_CYCLES + 2 * NODES + 100);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Wait for every response, then linger long enough to catch a stray one.
    wait (n_sent == total_requests && n_got == total_requests);
    repeat (NODES + 8) @(posedge clk_i);
    if (awaited_responses.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, awaited_responses.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Request side: offer queued requests after their gap; predict on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    list_request_t nxt;
    logic          valid_n;
    int            sent_n;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_req   <= '0;
      gap_cnt  <= 0;
      n_sent   <= 0;
    end else begin
      valid_n = in_valid;
      sent_n  = n_sent;
      if (in_valid && !in_stall_o) begin
        awaited_responses.push_back(apply_list_action(in_req));
        sent_n  = n_sent + 1;
        valid_n = 1'b0;
      end
      // Hold a stalled request as is; otherwise advance to the next one.
      if (!valid_n && pending_requests.size() != 0) begin
        if (gap_cnt >= pending_requests[0].gap &&
            (!pending_requests[0].drain || n_got == sent_n)) begin
          nxt     = pending_requests.pop_front();
          in_req  <= nxt.req;
          valid_n = 1'b1;
          gap_cnt <= 0;
        end else begin
          gap_cnt <= gap_cnt + 1;
        end
      end
      in_valid <= valid_n;
      n_sent   <= sent_n;
    end
  end

  // Response side: check each response, then stall for a drawn number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin : response_monitor
    int hold_n;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      n_got     <= 0;
    end else begin
      hold_n = (hold_left > 0) ? hold_left - 1 : 0;
      if (out_valid_o && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %p", $time, out_rsp);
          failed = 1'b1;
        end else begin
          compare_response(awaited_responses.pop_front(), out_rsp);
        end
        n_got <= n_got + 1;
        // Hold off once for a long stretch so the block backs up into its input.
        if (n_got + 1 == HOLDOFF_AT)
          hold_n = HOLDOFF_CYCLES;
        else if ((n_got + 1) % 64 < 16)
          hold_n = 0;
        else
          hold_n = $urandom_range(0, GAP_MAX);
      end
      hold_left <= hold_n;
      out_stall <= (hold_n != 0);
    end
  end

  // Drop the run if it takes far longer than the slowest correct run could.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

endmodule
